@@ rtl/mipmap_box_downsampler_defines.svh @@
// Assertion macros for the top-level RTL file of the mipmap box downsampler.
`ifndef MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define MBD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define MBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mbd_pkg.sv @@
// Package with constants, types and channel arithmetic of the mipmap box downsampler.
`default_nettype none

package mbd_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int HEIGHT_CAP = 512;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam int PIXEL_W  = 32;
    localparam int SIZE_W   = 10;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int PSUM_W   = CHAN_W + 1;
    localparam int PAIR_W   = PSUM_W * NUM_CHAN;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_CAP);
    localparam int ADDR_W = $clog2(LINE_DEPTH);

    // Common width for comparing counters against the effective sizes.
    localparam int CMP_A = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int CMP_W = (CMP_A > ROW_W + 1) ? CMP_A : ROW_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CHAN_W-1:0] ALPHA_THRESHOLD = 8'd128;
    localparam logic [CHAN_W-1:0] ALPHA_FULL      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_ALPHA_CUT     = 2'd2
    } cfg_reg_t;

    typedef logic [PAIR_W-1:0] pair_sum_t;

    // Channel-wise sums of two pixels, four 9-bit fields, red lowest.
    function automatic pair_sum_t pair_sum(input logic [PIXEL_W-1:0] a,
                                           input logic [PIXEL_W-1:0] b);
        pair_sum_t r;
        r = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            r[c*PSUM_W +: PSUM_W] = PSUM_W'(a[c*CHAN_W +: CHAN_W])
                                  + PSUM_W'(b[c*CHAN_W +: CHAN_W]);
        end
        return r;
    endfunction

    // Average of a 2x2 block from its top and bottom pair sums, truncating; with cut, alpha is 0 or 255.
    function automatic logic [PIXEL_W-1:0] block_average(input pair_sum_t top,
                                                         input pair_sum_t bottom,
                                                         input logic      cut);
        logic [PIXEL_W-1:0] res;
        logic [PSUM_W:0]    s;
        logic [CHAN_W-1:0]  avg;
        res = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            s   = (PSUM_W+1)'(top[c*PSUM_W +: PSUM_W]) + (PSUM_W+1)'(bottom[c*PSUM_W +: PSUM_W]);
            avg = s[PSUM_W:2];
            if (c == NUM_CHAN - 1 && cut) begin
                avg = (avg >= ALPHA_THRESHOLD) ? ALPHA_FULL : '0;
            end
            res[c*CHAN_W +: CHAN_W] = avg;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mipmap_box_downsampler.sv @@
// Top level of the mipmap box downsampler: counters, pair-sum line memory and output stage.
//
// One source pixel is taken per cycle in raster order, and one averaged pixel leaves for
// every completed 2x2 block. It is offered on the result channel once the bottom-right
// source pixel's sums have passed the line memory read stage and then the output register.
// The sustained rate is one pixel per clock. The only throttle is back-pressure on the
// result channel, which holds the input once both the memory read stage and the output
// register are full. Top-row pair sums live in a 256-entry single-write, single-read
// line memory with a registered read. An entry is always written a full source row
// before it is read, so no forwarding is needed. There is no clearing pass after reset.
// Sizes outside 1..512 are clamped, and a trailing odd column or row is taken and dropped.
`default_nettype none

module mipmap_box_downsampler
    import mbd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIXEL_W-1:0]    s_source_pixel,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIXEL_W-1:0]         m_dest_pixel,
    output logic                       m_last_of_image,

    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "mipmap_box_downsampler_defines.svh"

    // Configuration registers.
    logic [SIZE_W-1:0] source_width_reg;
    logic [SIZE_W-1:0] source_height_reg;
    logic              alpha_cut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= SIZE_W'(MAX_WIDTH);
            source_height_reg <= SIZE_W'(HEIGHT_CAP);
            alpha_cut_reg     <= 1'b0;
        end else if (cfg_write_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_ALPHA_CUT:     alpha_cut_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes after clamping.
    logic [CMP_W-1:0] width_ext, height_ext;
    logic [CMP_W-1:0] width_eff, height_eff;
    logic [CMP_W-1:0] width_even, height_even;

    always_comb begin
        width_ext  = CMP_W'(source_width_reg);
        height_ext = CMP_W'(source_height_reg);
        if (width_ext == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext == '0) begin
            height_eff = CMP_W'(1);
        end else if (height_ext > CMP_W'(HEIGHT_CAP)) begin
            height_eff = CMP_W'(HEIGHT_CAP);
        end else begin
            height_eff = height_ext;
        end
        width_even  = {width_eff[CMP_W-1:1], 1'b0};
        height_even = {height_eff[CMP_W-1:1], 1'b0};
    end

    // Pipeline control.
    logic a_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic a_free;
    logic accept;

    assign out_free = !m_valid_reg || m_ready;
    assign a_free   = !a_valid_reg || out_free;
    assign s_ready  = a_free;
    assign accept   = s_valid && s_ready;

    // Position counters and the held left pixel.
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PIXEL_W-1:0] left_pixel_reg;
    logic [CMP_W-1:0]   col_ext, row_ext;
    logic               in_block;
    logic               line_we;
    logic               line_re;
    logic               is_last;
    logic [ADDR_W-1:0]  line_addr;
    pair_sum_t          cur_pair;

    always_comb begin
        col_ext   = CMP_W'(col_reg);
        row_ext   = CMP_W'(row_reg);
        in_block  = col_reg[0] && (col_ext < width_even) && (row_ext < height_even);
        line_we   = accept && in_block && !row_reg[0];
        line_re   = accept && in_block && row_reg[0];
        line_addr = col_reg[COL_W-1:1];
        cur_pair  = pair_sum(left_pixel_reg, s_source_pixel);
        is_last   = (col_ext == width_even - CMP_W'(1))
                 && (row_ext == height_even - CMP_W'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_ext + CMP_W'(1) >= width_eff) begin
                col_next = '0;
                row_next = (row_ext + CMP_W'(1) >= height_eff) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_pixel_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && !col_reg[0]) begin
                left_pixel_reg <= s_source_pixel;
            end
        end
    end

    // Line memory of top-row pair sums, registered read.
    pair_sum_t line_mem [LINE_DEPTH];
    pair_sum_t top_pair_reg;

    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[line_addr] <= cur_pair;
        end
        if (line_re) begin
            top_pair_reg <= line_mem[line_addr];
        end
    end

    // Read stage: bottom pair sum and last flag wait beside the memory output.
    pair_sum_t bot_pair_reg;
    logic      a_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= line_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_re) begin
            bot_pair_reg <= cur_pair;
            a_last_reg   <= is_last;
        end
    end

    // Output register.
    logic [PIXEL_W-1:0] m_dest_pixel_reg;
    logic               m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && a_valid_reg) begin
            m_dest_pixel_reg <= block_average(top_pair_reg, bot_pair_reg, alpha_cut_reg);
            m_last_reg       <= a_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_dest_pixel    = m_dest_pixel_reg;
    assign m_last_of_image = m_last_reg;

    // A request in the read stage must reach the output register once it has room.
    `MBD_ASSERT_NEXT(a_moves_to_out, aclk, aresetn, a_valid_reg && out_free, m_valid_reg, "read stage request was lost")
    // A request held in the read stage keeps its bottom pair sum.
    `MBD_ASSERT_NEXT(a_hold_stable, aclk, aresetn, a_valid_reg && !out_free, a_valid_reg && $stable(bot_pair_reg), "stalled read stage changed")
    // The input only stalls when both stages are full and the output is blocked.
    `MBD_ASSERT_SAME(stall_reason, aclk, aresetn, !s_ready, a_valid_reg && m_valid_reg && !m_ready, "input stalled without back-pressure")

endmodule

`default_nettype wire
